### rtl/alms_pkg.sv
// alms_pkg: shared types, constants and arithmetic helpers of the alpha mask blender
// depends on nothing; imported by alms_prep, alms_div_lane and alpha_mask_src_over_blend
`timescale 1ns / 1ps
`default_nettype none

package alms_pkg;

   localparam int unsigned CHANNELS    = 3;
   localparam int unsigned SUM_W       = 17;
   localparam int unsigned PREP_STAGES = 5;
   localparam int unsigned DIV_STAGES  = 4;
   localparam int unsigned LANE_LAT    = DIV_STAGES + 1;
   localparam int unsigned PIPE_LAT    = PREP_STAGES + LANE_LAT + 1;

   // ceil(2^32 / 255), exact for 24-bit dividends up to 255^3
   localparam logic [24:0] RECIP_255 = 25'd16843010;

   typedef enum logic [1:0] {
      CSR_OVERLAY_COLOR = 2'd0,
      CSR_FRAME_WIDTH   = 2'd1,
      CSR_FRAME_HEIGHT  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic        valid;
      logic        write;
      logic [7:0]  oa;
      logic [31:0] dest;
   } side_type;

   typedef struct packed {
      side_type                        side;
      logic [CHANNELS-1:0][SUM_W-1:0]  sum;
   } prep_type;

   typedef struct packed {
      logic [SUM_W-1:0] rem;
      logic             qbit;
   } step_type;

   // x / 255 for x below 65280 (255 * 256)
   function automatic logic [7:0] div255_small(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

   // x / 255 for x up to 255^3, by reciprocal multiplication
   function automatic logic [15:0] div255_wide(input logic [23:0] x);
      logic [48:0] p;
      p = {25'b0, x} * {24'b0, RECIP_255};
      return p[47:32];
   endfunction

   // one restoring division step at quotient bit position pos
   function automatic step_type div_step(input logic [SUM_W-1:0] rem,
                                         input logic [7:0] dv,
                                         input int unsigned pos);
      logic [SUM_W-1:0] sh;
      step_type         r;
      sh = {{(SUM_W-8){1'b0}}, dv} << pos;
      if (rem >= sh) begin
         r.rem  = rem - sh;
         r.qbit = 1'b1;
      end else begin
         r.rem  = rem;
         r.qbit = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/alms_prep.sv
// alms_prep: five-stage front end: clipping, effective alpha, output alpha
// and the weighted channel sums; uses alms_pkg
`timescale 1ns / 1ps
`default_nettype none

module alms_prep (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic [7:0]         coverage,
   input  wire logic [31:0]        dest_pixel,
   input  wire logic signed [15:0] dest_col,
   input  wire logic signed [15:0] dest_row,
   input  wire logic [31:0]        overlay_color,
   input  wire logic [14:0]        frame_width,
   input  wire logic [14:0]        frame_height,
   output alms_pkg::prep_type      prep_out
);
   import alms_pkg::*;

   // stage 1
   logic        v1_ff;
   logic [15:0] cov_mul_in, cov_mul_ff;
   logic        inside_in, inside_ff;
   logic [31:0] dest1_ff;
   // stage 2
   logic        v2_ff;
   logic [7:0]  alpha_in, alpha_ff;
   logic [15:0] w_in, w_ff;
   logic        write2_ff;
   logic [31:0] dest2_ff;
   // stage 3
   logic        v3_ff;
   logic [8:0]  oa_sum;
   logic [7:0]  oa3_in, oa3_ff;
   logic [CHANNELS-1:0][15:0] sa3_in, sa3_ff;
   logic [CHANNELS-1:0][23:0] dw3_in, dw3_ff;
   logic        write3_ff;
   logic [31:0] dest3_ff;
   // stage 4
   logic        v4_ff;
   logic [7:0]  oa4_ff;
   logic [CHANNELS-1:0][15:0] sa4_ff;
   logic [CHANNELS-1:0][15:0] q4_in, q4_ff;
   logic        write4_ff;
   logic [31:0] dest4_ff;
   // stage 5
   prep_type    prep_in, prep_ff;

   logic [7:0]  col_src [CHANNELS];
   logic [7:0]  col_dst [CHANNELS];

   always_comb begin
      col_src[2] = overlay_color[31:24];
      col_src[1] = overlay_color[23:16];
      col_src[0] = overlay_color[15:8];
      col_dst[2] = dest2_ff[23:16];
      col_dst[1] = dest2_ff[15:8];
      col_dst[0] = dest2_ff[7:0];
   end

   always_comb begin
      cov_mul_in = {8'b0, ~overlay_color[7:0]} * {8'b0, coverage};
      inside_in  = !dest_col[15] && (dest_col[14:0] < frame_width) &&
                   !dest_row[15] && (dest_row[14:0] < frame_height);
   end

   always_comb begin
      alpha_in = div255_small(cov_mul_ff);
      w_in     = {8'b0, dest1_ff[31:24]} * {8'b0, 8'hFF - alpha_in};
   end

   always_comb begin
      oa_sum = {1'b0, alpha_ff} + {1'b0, div255_small(w_ff)};
      oa3_in = oa_sum[8] ? 8'hFF : oa_sum[7:0];
      for (int c = 0; c < CHANNELS; c++) begin
         sa3_in[c] = {8'b0, col_src[c]} * {8'b0, alpha_ff};
         dw3_in[c] = {16'b0, col_dst[c]} * {8'b0, w_ff};
      end
   end

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         q4_in[c] = div255_wide(dw3_ff[c]);
      end
   end

   always_comb begin
      prep_in.side.valid = v4_ff;
      prep_in.side.write = write4_ff;
      prep_in.side.oa    = oa4_ff;
      prep_in.side.dest  = dest4_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         prep_in.sum[c] = {1'b0, sa4_ff[c]} + {1'b0, q4_ff[c]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         prep_ff <= '0;
      end else begin
         v1_ff   <= in_valid;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         v4_ff   <= v3_ff;
         prep_ff <= prep_in;
      end
   end

   always_ff @(posedge clock) begin
      cov_mul_ff <= cov_mul_in;
      inside_ff  <= inside_in;
      dest1_ff   <= dest_pixel;

      alpha_ff   <= alpha_in;
      w_ff       <= w_in;
      write2_ff  <= inside_ff && (alpha_in != 8'd0);
      dest2_ff   <= dest1_ff;

      oa3_ff     <= oa3_in;
      sa3_ff     <= sa3_in;
      dw3_ff     <= dw3_in;
      write3_ff  <= write2_ff;
      dest3_ff   <= dest2_ff;

      oa4_ff     <= oa3_ff;
      sa4_ff     <= sa3_ff;
      q4_ff      <= q4_in;
      write4_ff  <= write3_ff;
      dest4_ff   <= dest3_ff;
   end

   assign prep_out = prep_ff;

endmodule

`default_nettype wire

### rtl/alms_div_lane.sv
// alms_div_lane: pipelined restoring divider for one colour channel,
// saturating the quotient at 255; uses alms_pkg
`timescale 1ns / 1ps
`default_nettype none

module alms_div_lane (
   input  wire logic                       clock,
   input  wire logic [alms_pkg::SUM_W-1:0] sum,
   input  wire logic [7:0]                 oa,
   output logic [7:0]                      quot
);
   import alms_pkg::*;

   logic [7:0]       div_in;
   logic             sat_in;
   logic [SUM_W-1:0] rem_ff [DIV_STAGES];
   logic [7:0]       div_ff [DIV_STAGES];
   logic [7:0]       quot_ff [DIV_STAGES+1];
   logic             sat_ff [DIV_STAGES+1];
   logic [SUM_W-1:0] rem_in [DIV_STAGES];
   logic [7:0]       quot_in [DIV_STAGES];

   always_comb begin
      div_in = (oa == 8'd0) ? 8'd1 : oa;
      // quotient of 256 or more clamps to full scale
      sat_in = sum >= {1'b0, div_in, 8'b0};
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= sum;
      div_ff[0]  <= div_in;
      quot_ff[0] <= 8'd0;
      sat_ff[0]  <= sat_in;
   end

   // two quotient bits per stage, high bits first
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      step_type hi, lo;

      always_comb begin
         hi = div_step(rem_ff[s], div_ff[s], 7 - 2 * s);
         lo = div_step(hi.rem, div_ff[s], 6 - 2 * s);
         rem_in[s]  = lo.rem;
         quot_in[s] = quot_ff[s];
         quot_in[s][7-2*s] = hi.qbit;
         quot_in[s][6-2*s] = lo.qbit;
      end

      always_ff @(posedge clock) begin
         quot_ff[s+1] <= quot_in[s];
         sat_ff[s+1]  <= sat_ff[s];
      end

      if (s + 1 < DIV_STAGES) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[s+1] <= rem_in[s];
            div_ff[s+1] <= div_ff[s];
         end
      end
   end

   assign quot = sat_ff[DIV_STAGES] ? 8'hFF : quot_ff[DIV_STAGES];

endmodule

`default_nettype wire

### rtl/alpha_mask_src_over_blend.sv
// alpha_mask_src_over_blend: source-over blend of an overlay-coloured mask pixel
// onto an ARGB8888 destination pixel; uses alms_pkg, alms_prep, alms_div_lane
// a transaction passes 11 registers before rsp_strobe rises
// throughput: one pixel per clock; busy stays low, every start is taken, no output stall
// five front-end stages, five divider stages per channel, one output register
// reset clears the configuration registers and all valid bits; nothing else to sweep
`timescale 1ns / 1ps
`default_nettype none

module alpha_mask_src_over_blend (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [7:0]         req_coverage,
   input  wire logic [31:0]        req_dest_pixel,
   input  wire logic signed [15:0] req_dest_col,
   input  wire logic signed [15:0] req_dest_row,
   output logic                    rsp_strobe,
   output logic [31:0]             rsp_new_pixel,
   output logic                    rsp_write_pixel,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);
   import alms_pkg::*;

   logic [31:0] overlay_color_ff;
   logic [14:0] frame_width_ff;
   logic [14:0] frame_height_ff;

   prep_type    prep;
   side_type    side_ff [LANE_LAT];
   logic [CHANNELS-1:0][7:0] quot;

   logic        strobe_in, strobe_ff;
   logic [31:0] pixel_in, pixel_ff;
   logic        write_in, write_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         overlay_color_ff <= 32'd0;
         frame_width_ff   <= 15'd0;
         frame_height_ff  <= 15'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OVERLAY_COLOR: overlay_color_ff <= csr_wdata;
            CSR_FRAME_WIDTH:   frame_width_ff   <= csr_wdata[14:0];
            CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   alms_prep u_prep (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (start && !busy),
      .coverage      (req_coverage),
      .dest_pixel    (req_dest_pixel),
      .dest_col      (req_dest_col),
      .dest_row      (req_dest_row),
      .overlay_color (overlay_color_ff),
      .frame_width   (frame_width_ff),
      .frame_height  (frame_height_ff),
      .prep_out      (prep)
   );

   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      alms_div_lane u_lane (
         .clock (clock),
         .sum   (prep.sum[c]),
         .oa    (prep.side.oa),
         .quot  (quot[c])
      );
   end

   // sideband follows the divider lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_LAT; i++) begin
            side_ff[i] <= '0;
         end
      end else begin
         side_ff[0] <= prep.side;
         for (int i = 1; i < LANE_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   always_comb begin
      strobe_in = side_ff[LANE_LAT-1].valid;
      write_in  = side_ff[LANE_LAT-1].write;
      pixel_in  = write_in ? {side_ff[LANE_LAT-1].oa, quot[2], quot[1], quot[0]}
                           : side_ff[LANE_LAT-1].dest;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
      write_ff <= write_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_new_pixel   = pixel_ff;
   assign rsp_write_pixel = write_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##PIPE_LAT rsp_strobe)
      else $error("transaction did not produce a result at the expected latency");

   a_written_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_write_pixel |-> rsp_new_pixel[31:24] != 8'd0)
      else $error("written pixel carries zero alpha");

   a_passthrough: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_write_pixel |-> rsp_new_pixel == $past(req_dest_pixel, PIPE_LAT))
      else $error("unwritten pixel differs from the destination pixel");

endmodule

`default_nettype wire
